[rtl/bw_pkg.sv]
// Shared types and constants for the barycentric weights unit.
`timescale 1ns / 1ps
package bw_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WEIGHT_BITS = 24;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int NUM_REGS = 6;
  localparam int IDX_W = 3;
  localparam int FIFO_DEPTH = 4;

  localparam logic [IDX_W-1:0] REG_V0X = 3'd0;
  localparam logic [IDX_W-1:0] REG_V0Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_V1X = 3'd2;
  localparam logic [IDX_W-1:0] REG_V1Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_V2X = 3'd4;
  localparam logic [IDX_W-1:0] REG_V2Y = 3'd5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_u;
    logic signed [WEIGHT_BITS-1:0] weight_v;
    logic signed [WEIGHT_BITS-1:0] weight_w;
    logic                          degenerate;
  } result_t;

  // One classified item between front and back.
  typedef struct packed {
    logic signed [CROSS_W-1:0] num_v;
    logic signed [CROSS_W-1:0] num_w;
    logic signed [CROSS_W-1:0] det;
    logic                      degen;
  } work_t;
endpackage

[rtl/barycentric_weights_unit.sv]
// Top level of the barycentric weights unit.
`timescale 1ns / 1ps
// Barycentric weights of integer points against a triangle held in six registers.
// Configuration: cfg_we writes cfg_data to register cfg_index (0..5 = v0x, v0y, v1x,
// v1y, v2x, v2y); other indexes are dropped. After a write busy stays high
// while the edge vectors and determinant are rebuilt.
// Input: a point transfers on a rising edge with start high and busy low.
// Output: result_valid is high for one cycle with weight_u/v/w (signed Q8.16 by
// default, saturated) and the degenerate flag; the receiver cannot stall it.
// Throughput: one point per clock while busy is low. Stages: 3 front stages, one
// queue stage, then magnitude, load, one stage per quotient bit (24), clamp and
// output stages; the first front stage loads on the transfer edge. The divider
// is fully pipelined, one restoring step per stage, so the queue never fills.
// Reset: registers read 0 (degenerate triangle), all pipelines empty, busy is
// high while the edge vectors and determinant are rebuilt.
module barycentric_weights_unit #(
  parameter int FRAC_BITS = bw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bw_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bw_pkg::COORD_BITS-1:0] cfg_data,
  input  logic                          start,
  input  bw_pkg::point_t                point,
  output logic                          busy,
  output logic                          result_valid,
  output bw_pkg::result_t               result
);
  import bw_pkg::*;

  logic  push, not_empty;
  work_t push_data, pop_data;

  bw_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .start, .point, .busy,
    .push, .push_data
  );

  bw_fifo u_fifo (
    .clk, .rst, .push, .push_data, .pop(not_empty), .not_empty, .pop_data
  );

  bw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(not_empty), .in_data(pop_data), .result_valid, .result
  );
endmodule

[rtl/bw_front.sv]
// Front part: vertex registers, determinant, and per-point cross products.
`timescale 1ns / 1ps
module bw_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bw_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bw_pkg::COORD_BITS-1:0] cfg_data,
  input  logic                        start,
  input  bw_pkg::point_t              point,
  output logic                        busy,
  output logic                        push,
  output bw_pkg::work_t               push_data
);
  import bw_pkg::*;

  logic signed [COORD_BITS-1:0] vx0, vy0, vx1, vy1, vx2, vy2;
  logic signed [DIFF_W-1:0] e1x, e1y, e2x, e2y;
  logic signed [PROD_W-1:0] d_a, d_b;
  logic signed [CROSS_W-1:0] det;
  logic [1:0] settle;

  logic                     s1_valid, s2_valid, s3_valid;
  logic signed [DIFF_W-1:0] px, py;
  logic signed [PROD_W-1:0] m_pe2y, m_pye2x, m_e1xpy, m_e1ypx;
  work_t                    s3_data;

  assign busy = (settle != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vx0 <= '0; vy0 <= '0; vx1 <= '0; vy1 <= '0; vx2 <= '0; vy2 <= '0;
      settle <= 2'd3;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_V0X: vx0 <= cfg_data;
          REG_V0Y: vy0 <= cfg_data;
          REG_V1X: vx1 <= cfg_data;
          REG_V1Y: vy1 <= cfg_data;
          REG_V2X: vx2 <= cfg_data;
          REG_V2Y: vy2 <= cfg_data;
          default: ;
        endcase
        settle <= 2'd3;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  // Determinant pipeline: edges, products, difference.
  always_ff @(posedge clk) begin
    e1x <= DIFF_W'(vx1) - DIFF_W'(vx0);
    e1y <= DIFF_W'(vy1) - DIFF_W'(vy0);
    e2x <= DIFF_W'(vx2) - DIFF_W'(vx0);
    e2y <= DIFF_W'(vy2) - DIFF_W'(vy0);
    d_a <= e1x * e2y;
    d_b <= e1y * e2x;
    det <= CROSS_W'(d_a) - CROSS_W'(d_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    px <= DIFF_W'(point.point_x) - DIFF_W'(vx0);
    py <= DIFF_W'(point.point_y) - DIFF_W'(vy0);
    m_pe2y  <= px * e2y;
    m_pye2x <= py * e2x;
    m_e1xpy <= e1x * py;
    m_e1ypx <= e1y * px;
    s3_data.num_v <= CROSS_W'(m_pe2y) - CROSS_W'(m_pye2x);
    s3_data.num_w <= CROSS_W'(m_e1xpy) - CROSS_W'(m_e1ypx);
    s3_data.det   <= det;
    s3_data.degen <= (det == '0);
  end

  assign push      = s3_valid;
  assign push_data = s3_data;
endmodule

[rtl/bw_fifo.sv]
// Short queue between the front and the divider back end.
`timescale 1ns / 1ps
module bw_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bw_pkg::work_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output bw_pkg::work_t pop_data
);
  import bw_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  work_t         mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(do_pop);
    end
  end
endmodule

[rtl/bw_back.sv]
// Back part: pipelined restoring dividers for v and w, then u and output.
`timescale 1ns / 1ps
module bw_back #(
  parameter int FRAC_BITS = bw_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  bw_pkg::work_t   in_data,
  output logic            result_valid,
  output bw_pkg::result_t result
);
  import bw_pkg::*;

  localparam int WB = WEIGHT_BITS;
  localparam int DW = CROSS_W + FRAC_BITS + WB;
  localparam int UW = WB + 3;
  localparam logic [WB-1:0] LIM_POS = {1'b0, {(WB-1){1'b1}}};
  localparam logic [WB-1:0] LIM_NEG = {1'b1, {(WB-1){1'b0}}};

  // Magnitude stage.
  logic               e_valid, e_degen, e_neg_v, e_neg_w;
  logic [CROSS_W-1:0] e_av, e_aw, e_b;

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else     e_valid <= in_valid;
    e_av    <= in_data.num_v[CROSS_W-1] ? CROSS_W'(-in_data.num_v) : CROSS_W'(in_data.num_v);
    e_aw    <= in_data.num_w[CROSS_W-1] ? CROSS_W'(-in_data.num_w) : CROSS_W'(in_data.num_w);
    e_b     <= in_data.det[CROSS_W-1] ? CROSS_W'(-in_data.det) : CROSS_W'(in_data.det);
    e_neg_v <= in_data.num_v[CROSS_W-1] != in_data.det[CROSS_W-1];
    e_neg_w <= in_data.num_w[CROSS_W-1] != in_data.det[CROSS_W-1];
    e_degen <= in_data.degen;
  end

  // Divider stage arrays; entry 0 is the loaded dividend.
  logic          d_valid [WB+1];
  logic          d_degen [WB+1];
  logic          d_neg_v [WB+1];
  logic          d_neg_w [WB+1];
  logic          d_ovf_v [WB+1];
  logic          d_ovf_w [WB+1];
  logic [DW-1:0] d_b     [WB+1];
  logic [DW-1:0] d_rv    [WB+1];
  logic [DW-1:0] d_rw    [WB+1];
  logic [WB-1:0] d_qv    [WB+1];
  logic [WB-1:0] d_qw    [WB+1];

  // Load: flag quotients that cannot fit in WB bits.
  always_ff @(posedge clk) begin
    if (rst) d_valid[0] <= 1'b0;
    else     d_valid[0] <= e_valid;
    d_degen[0] <= e_degen;
    d_neg_v[0] <= e_neg_v;
    d_neg_w[0] <= e_neg_w;
    d_b[0]     <= DW'(e_b);
    d_rv[0]    <= DW'(e_av) << FRAC_BITS;
    d_rw[0]    <= DW'(e_aw) << FRAC_BITS;
    d_ovf_v[0] <= (DW'(e_av) << FRAC_BITS) >= (DW'(e_b) << WB);
    d_ovf_w[0] <= (DW'(e_aw) << FRAC_BITS) >= (DW'(e_b) << WB);
    d_qv[0]    <= '0;
    d_qw[0]    <= '0;
  end

  for (genvar i = 0; i < WB; i++) begin : g_div
    localparam int BIT = WB - 1 - i;
    logic [DW-1:0] sh;
    logic          tv, tw;
    assign sh = d_b[i] << BIT;
    assign tv = d_rv[i] >= sh;
    assign tw = d_rw[i] >= sh;

    always_ff @(posedge clk) begin
      if (rst) d_valid[i+1] <= 1'b0;
      else     d_valid[i+1] <= d_valid[i];
      d_degen[i+1] <= d_degen[i];
      d_neg_v[i+1] <= d_neg_v[i];
      d_neg_w[i+1] <= d_neg_w[i];
      d_ovf_v[i+1] <= d_ovf_v[i];
      d_ovf_w[i+1] <= d_ovf_w[i];
      d_b[i+1]     <= d_b[i];
      d_rv[i+1]    <= tv ? d_rv[i] - sh : d_rv[i];
      d_rw[i+1]    <= tw ? d_rw[i] - sh : d_rw[i];
      d_qv[i+1]    <= d_qv[i] | (WB'(tv) << BIT);
      d_qw[i+1]    <= d_qw[i] | (WB'(tw) << BIT);
    end
  end

  // Clamp and apply sign.
  logic                 f_valid, f_degen;
  logic signed [WB-1:0] f_v, f_w;

  function automatic logic [WB-1:0] signed_clamp(input logic [WB-1:0] q, input logic neg,
                                                 input logic ovf);
    logic [WB-1:0] lim;
    logic [WB-1:0] mag;
    lim = neg ? LIM_NEG : LIM_POS;
    mag = (ovf || q > lim) ? lim : q;
    return neg ? WB'(-mag) : mag;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else     f_valid <= d_valid[WB];
    f_degen <= d_degen[WB];
    f_v <= d_degen[WB] ? '0 : signed_clamp(d_qv[WB], d_neg_v[WB], d_ovf_v[WB]);
    f_w <= d_degen[WB] ? '0 : signed_clamp(d_qw[WB], d_neg_w[WB], d_ovf_w[WB]);
  end

  // u = 1 - v - w, saturated.
  logic signed [UW-1:0] u_full;
  logic signed [WB-1:0] u_sat;
  assign u_full = (UW'(1) << FRAC_BITS) - UW'(f_v) - UW'(f_w);
  always_comb begin
    if (u_full > UW'(signed'({1'b0, LIM_POS})))
      u_sat = LIM_POS;
    else if (u_full < signed'({{(UW-WB){1'b1}}, LIM_NEG}))
      u_sat = LIM_NEG;
    else
      u_sat = u_full[WB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= f_valid;
    result.weight_u   <= f_degen ? '0 : u_sat;
    result.weight_v   <= f_v;
    result.weight_w   <= f_w;
    result.degenerate <= f_degen;
  end
endmodule
